>>> hw/rtl/ftvd_pkg.sv
package ftvd_pkg;

    // Table geometry and identifier width.
    localparam int TABLE_CAPACITY = 4096;
    localparam int ID_BITS        = 24;
    localparam int FIELD_W        = 24;
    localparam int ADDR_W         = $clog2(TABLE_CAPACITY);
    localparam int CNT_W          = ADDR_W + 1;
    localparam int VIDX_W         = 12;

    // Result status codes.
    typedef logic [1:0] status_t;
    localparam status_t STATUS_REUSED = 2'd0;
    localparam status_t STATUS_NEW    = 2'd1;
    localparam status_t STATUS_FULL   = 2'd2;

    // One corner triple as it is stored in the table.
    typedef struct packed {
        logic [ID_BITS-1:0] pos;
        logic [ID_BITS-1:0] coord;
        logic [ID_BITS-1:0] normal;
    } key_t;

    localparam int ENTRY_W = $bits(key_t);

    // Lookup request from the face sequencer to the search unit.
    typedef struct packed {
        logic start;
        key_t key;
    } lookup_req_t;

    // Lookup response from the search unit.
    typedef struct packed {
        logic              done;
        logic [ADDR_W-1:0] idx;
        status_t           status;
    } lookup_rsp_t;

endpackage

>>> hw/rtl/ftvd_ram.sv
module ftvd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Single write port, registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/ftvd_search.sv
module ftvd_search (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ftvd_pkg::lookup_req_t req,
    output ftvd_pkg::lookup_rsp_t rsp
);

    localparam logic [1:0] SS_IDLE   = 2'd0;
    localparam logic [1:0] SS_SCAN   = 2'd1;
    localparam logic [1:0] SS_APPEND = 2'd2;

    logic [1:0]                     state_reg, state_next;
    ftvd_pkg::key_t                 key_reg, key_next;
    logic [ftvd_pkg::CNT_W-1:0]     rd_addr_reg, rd_addr_next;
    logic                           cmp_valid_reg, cmp_valid_next;
    logic [ftvd_pkg::ADDR_W-1:0]    cmp_addr_reg, cmp_addr_next;
    logic [ftvd_pkg::CNT_W-1:0]     count_reg, count_next;
    logic                           done_reg, done_next;
    logic [ftvd_pkg::ADDR_W-1:0]    idx_reg, idx_next;
    ftvd_pkg::status_t              status_reg, status_next;

    logic                           ram_we;
    logic [ftvd_pkg::ENTRY_W-1:0]   ram_rdata;
    logic                           issue;
    logic                           hit;

    // Table of unique triples, kept in first-seen order.
    ftvd_ram #(
        .WIDTH (ftvd_pkg::ENTRY_W),
        .DEPTH (ftvd_pkg::TABLE_CAPACITY)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (count_reg[ftvd_pkg::ADDR_W-1:0]),
        .wr_data (key_reg),
        .rd_addr (rd_addr_reg[ftvd_pkg::ADDR_W-1:0]),
        .rd_data (ram_rdata)
    );

    // One read issued per cycle while entries remain; each is compared in the next cycle.
    assign issue = (state_reg == SS_SCAN) && (rd_addr_reg < count_reg);
    assign hit   = cmp_valid_reg && (ram_rdata == key_reg);

    // Search sequencer.
    always_comb
    begin
        state_next     = state_reg;
        key_next       = key_reg;
        rd_addr_next   = rd_addr_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_addr_next  = cmp_addr_reg;
        count_next     = count_reg;
        done_next      = 1'b0;
        idx_next       = idx_reg;
        status_next    = status_reg;
        ram_we         = 1'b0;

        unique case (state_reg)
            SS_IDLE:
            begin
                if (req.start)
                begin
                    key_next       = req.key;
                    rd_addr_next   = '0;
                    cmp_valid_next = 1'b0;
                    state_next     = SS_SCAN;
                end
            end
            SS_SCAN:
            begin
                cmp_valid_next = issue;
                cmp_addr_next  = rd_addr_reg[ftvd_pkg::ADDR_W-1:0];
                if (issue)
                begin
                    rd_addr_next = rd_addr_reg + ftvd_pkg::CNT_W'(1);
                end
                priority if (hit)
                begin
                    done_next      = 1'b1;
                    idx_next       = cmp_addr_reg;
                    status_next    = ftvd_pkg::STATUS_REUSED;
                    cmp_valid_next = 1'b0;
                    state_next     = SS_IDLE;
                end
                else if (!cmp_valid_reg && !issue)
                begin
                    state_next = SS_APPEND;
                end
            end
            SS_APPEND:
            begin
                done_next  = 1'b1;
                state_next = SS_IDLE;
                if (count_reg < ftvd_pkg::CNT_W'(ftvd_pkg::TABLE_CAPACITY))
                begin
                    ram_we      = 1'b1;
                    idx_next    = count_reg[ftvd_pkg::ADDR_W-1:0];
                    status_next = ftvd_pkg::STATUS_NEW;
                    count_next  = count_reg + ftvd_pkg::CNT_W'(1);
                end
                else
                begin
                    idx_next    = '0;
                    status_next = ftvd_pkg::STATUS_FULL;
                end
            end
            default:
            begin
                state_next = SS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SS_IDLE;
            cmp_valid_reg <= 1'b0;
            count_reg     <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cmp_valid_reg <= cmp_valid_next;
            count_reg     <= count_next;
            done_reg      <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg      <= key_next;
        rd_addr_reg  <= rd_addr_next;
        cmp_addr_reg <= cmp_addr_next;
        idx_reg      <= idx_next;
        status_reg   <= status_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.idx    = idx_reg;
    assign rsp.status = status_reg;

endmodule

>>> hw/rtl/fan_triangulate_vertex_dedup.sv
// Fan triangulation with vertex deduplication.
// Face corners enter on the corner channel (corner_valid / corner_stall) and
// triangle corners leave on the result channel (result_valid / result_stall).
// An item is taken at a clock edge where valid is high and stall is low.
// The first two corners of a face produce nothing.
// Every later corner produces one fan triangle: anchor, previous, current,
// each looked up in a table of unique triples with a linear scan.
// With U table entries and one table read per cycle, a lookup that matches
// entry k stops there, and a miss reads all U entries and then appends the
// triple if there is room. An emitting corner holds corner_stall high for
// its three lookups and while the receiver stalls.
// Results leave through an output register; a new corner is taken while the
// last result of the previous one still waits there. When the receiver
// stalls, the result is held unchanged and the lookup sequence waits.
// Reset empties the table, clears the face and piece state and drops any
// pending result; the block is ready as soon as reset is released.
module fan_triangulate_vertex_dedup (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           corner_valid,
    output logic                           corner_stall,
    input  logic [ftvd_pkg::FIELD_W-1:0]   pos_index,
    input  logic [ftvd_pkg::FIELD_W-1:0]   coord_index,
    input  logic [ftvd_pkg::FIELD_W-1:0]   normal_index,
    input  logic                           first_of_face,
    input  logic                           piece_start,
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [ftvd_pkg::VIDX_W-1:0]    vertex_index,
    output logic [1:0]                     status,
    output logic [ftvd_pkg::FIELD_W-1:0]   out_pos,
    output logic [ftvd_pkg::FIELD_W-1:0]   out_coord,
    output logic [ftvd_pkg::FIELD_W-1:0]   out_normal,
    output logic                           piece_begin,
    output logic                           last
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;
    localparam logic [1:0] S_PUSH  = 2'd3;

    localparam logic [1:0] SLOT_ANCHOR = 2'd0;
    localparam logic [1:0] SLOT_PREV   = 2'd1;
    localparam logic [1:0] SLOT_CUR    = 2'd2;

    logic [1:0]                   state_reg, state_next;
    logic [1:0]                   corner_count_reg, corner_count_next;
    logic                         piece_pending_reg, piece_pending_next;
    logic [1:0]                   slot_reg, slot_next;
    ftvd_pkg::key_t               anchor_reg, anchor_next;
    ftvd_pkg::key_t               prev_reg, prev_next;
    ftvd_pkg::key_t               cur_reg, cur_next;
    logic [ftvd_pkg::ADDR_W-1:0]  hold_idx_reg, hold_idx_next;
    ftvd_pkg::status_t            hold_status_reg, hold_status_next;

    logic                         res_valid_reg, res_valid_next;
    logic [ftvd_pkg::VIDX_W-1:0]  res_idx_reg, res_idx_next;
    ftvd_pkg::status_t            res_status_reg, res_status_next;
    ftvd_pkg::key_t               res_key_reg, res_key_next;
    logic                         res_piece_reg, res_piece_next;
    logic                         res_last_reg, res_last_next;

    ftvd_pkg::key_t               in_key;
    ftvd_pkg::key_t               slot_key;
    ftvd_pkg::lookup_req_t        req;
    ftvd_pkg::lookup_rsp_t        rsp;
    logic                         corner_take;
    logic                         res_free;

    // Shared search unit with the triple table.
    ftvd_search u_search (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    // Incoming corner, masked to the identifier width.
    assign in_key.pos    = ftvd_pkg::ID_BITS'(pos_index);
    assign in_key.coord  = ftvd_pkg::ID_BITS'(coord_index);
    assign in_key.normal = ftvd_pkg::ID_BITS'(normal_index);

    assign corner_stall = (state_reg != S_IDLE);
    assign corner_take  = corner_valid && !corner_stall;
    assign res_free     = !res_valid_reg || !result_stall;

    // Triangle corner currently being looked up.
    always_comb
    begin
        unique case (slot_reg)
            SLOT_ANCHOR: slot_key = anchor_reg;
            SLOT_PREV:   slot_key = prev_reg;
            default:     slot_key = cur_reg;
        endcase
    end

    assign req.start = (state_reg == S_START);
    assign req.key   = slot_key;

    // Face sequencer and output register loading.
    always_comb
    begin
        state_next         = state_reg;
        corner_count_next  = corner_count_reg;
        piece_pending_next = piece_pending_reg;
        slot_next          = slot_reg;
        anchor_next        = anchor_reg;
        prev_next          = prev_reg;
        cur_next           = cur_reg;
        hold_idx_next      = hold_idx_reg;
        hold_status_next   = hold_status_reg;
        res_valid_next     = res_valid_reg && result_stall;
        res_idx_next       = res_idx_reg;
        res_status_next    = res_status_reg;
        res_key_next       = res_key_reg;
        res_piece_next     = res_piece_reg;
        res_last_next      = res_last_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (corner_take)
                begin
                    if (piece_start)
                    begin
                        piece_pending_next = 1'b1;
                    end
                    priority if (first_of_face || corner_count_reg == 2'd0)
                    begin
                        anchor_next       = in_key;
                        corner_count_next = 2'd1;
                        prev_next         = in_key;
                    end
                    else if (corner_count_reg == 2'd1)
                    begin
                        corner_count_next = 2'd2;
                        prev_next         = in_key;
                    end
                    else
                    begin
                        cur_next   = in_key;
                        slot_next  = SLOT_ANCHOR;
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (rsp.done)
                begin
                    hold_idx_next    = rsp.idx;
                    hold_status_next = rsp.status;
                    state_next       = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (res_free)
                begin
                    res_valid_next     = 1'b1;
                    res_idx_next       = ftvd_pkg::VIDX_W'(hold_idx_reg);
                    res_status_next    = hold_status_reg;
                    res_key_next       = slot_key;
                    res_piece_next     = piece_pending_reg;
                    res_last_next      = (slot_reg == SLOT_CUR);
                    piece_pending_next = 1'b0;
                    if (slot_reg == SLOT_CUR)
                    begin
                        prev_next  = cur_reg;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 2'd1;
                        state_next = S_START;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            corner_count_reg  <= 2'd0;
            piece_pending_reg <= 1'b0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            corner_count_reg  <= corner_count_next;
            piece_pending_reg <= piece_pending_next;
            res_valid_reg     <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        slot_reg        <= slot_next;
        anchor_reg      <= anchor_next;
        prev_reg        <= prev_next;
        cur_reg         <= cur_next;
        hold_idx_reg    <= hold_idx_next;
        hold_status_reg <= hold_status_next;
        res_idx_reg     <= res_idx_next;
        res_status_reg  <= res_status_next;
        res_key_reg     <= res_key_next;
        res_piece_reg   <= res_piece_next;
        res_last_reg    <= res_last_next;
    end

    assign result_valid = res_valid_reg;
    assign vertex_index = res_idx_reg;
    assign status       = res_status_reg;
    assign out_pos      = ftvd_pkg::FIELD_W'(res_key_reg.pos);
    assign out_coord    = ftvd_pkg::FIELD_W'(res_key_reg.coord);
    assign out_normal   = ftvd_pkg::FIELD_W'(res_key_reg.normal);
    assign piece_begin  = res_piece_reg;
    assign last         = res_last_reg;

endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam logic [ftvd_pkg::FIELD_W-1:0] ABSENT = {ftvd_pkg::FIELD_W{1'b1}};
    localparam int RANDOM_ITEMS   = 400;
    localparam int HOLDOFF_CYCLES = 400;
    localparam int CYCLE_LIMIT    = 4000000;

    // Result indices and status codes written into a directed row.
    typedef struct packed {
        logic                        typed;
        logic [ftvd_pkg::VIDX_W-1:0] vidx0;
        logic [ftvd_pkg::VIDX_W-1:0] vidx1;
        logic [ftvd_pkg::VIDX_W-1:0] vidx2;
        ftvd_pkg::status_t           st0;
        ftvd_pkg::status_t           st1;
        ftvd_pkg::status_t           st2;
    } typed_exp_t;

    // One face corner as offered to the block.
    typedef struct packed {
        logic [ftvd_pkg::FIELD_W-1:0] pos;
        logic [ftvd_pkg::FIELD_W-1:0] coord;
        logic [ftvd_pkg::FIELD_W-1:0] normal;
        logic                         first;
        logic                         piece;
        typed_exp_t                   want;
    } corner_in_t;

    // One triangle corner as it leaves the block.
    typedef struct packed {
        logic [ftvd_pkg::VIDX_W-1:0]  vidx;
        ftvd_pkg::status_t            st;
        logic [ftvd_pkg::FIELD_W-1:0] pos;
        logic [ftvd_pkg::FIELD_W-1:0] coord;
        logic [ftvd_pkg::FIELD_W-1:0] normal;
        logic                         piece;
        logic                         is_last;
    } corner_result_t;

    localparam typed_exp_t UNTYPED = '{1'b0, 12'd0, 12'd0, 12'd0,
                                       ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED,
                                       ftvd_pkg::STATUS_REUSED};

    localparam int DIRECTED_COUNT = 23;
    localparam corner_in_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // A continuation right after reset starts a face and latches a piece start.
        '{24'd0, 24'd0, 24'd0, 1'b0, 1'b1, UNTYPED},
        '{24'd1, 24'd1, 24'd1, 1'b0, 1'b0, UNTYPED},
        '{ABSENT, ABSENT, ABSENT, 1'b0, 1'b0,
          '{1'b1, 12'd0, 12'd1, 12'd2,
            ftvd_pkg::STATUS_NEW, ftvd_pkg::STATUS_NEW, ftvd_pkg::STATUS_NEW}},
        '{24'd5, 24'd6, 24'd7, 1'b0, 1'b0,
          '{1'b1, 12'd0, 12'd2, 12'd3,
            ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_NEW}},
        // A two-corner face keeps its piece start pending.
        '{24'd10, 24'd0, 24'd0, 1'b1, 1'b1, UNTYPED},
        '{24'd11, 24'd0, 24'd0, 1'b0, 1'b0, UNTYPED},
        // Piece start given on the second corner of a face.
        '{24'd0, 24'd0, 24'd0, 1'b1, 1'b0, UNTYPED},
        '{24'd1, 24'd1, 24'd1, 1'b0, 1'b1, UNTYPED},
        '{24'd2, 24'd3, 24'd4, 1'b0, 1'b0,
          '{1'b1, 12'd0, 12'd1, 12'd4,
            ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_NEW}},
        // Absent components mixed with present ones.
        '{ABSENT, 24'd0, ABSENT, 1'b1, 1'b0, UNTYPED},
        '{24'd0, ABSENT, 24'd0, 1'b0, 1'b0, UNTYPED},
        '{ABSENT, ABSENT, 24'd0, 1'b0, 1'b0,
          '{1'b1, 12'd5, 12'd6, 12'd7,
            ftvd_pkg::STATUS_NEW, ftvd_pkg::STATUS_NEW, ftvd_pkg::STATUS_NEW}},
        // Single-corner faces emit nothing and store nothing.
        '{ABSENT, 24'd0, ABSENT, 1'b1, 1'b0, UNTYPED},
        '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b1, 1'b0, UNTYPED},
        '{24'h555555, 24'hAAAAAA, 24'h555555, 1'b1, 1'b0, UNTYPED},
        // A degenerate face of one repeated corner, then a longer fan.
        '{24'd7, 24'd7, 24'd7, 1'b1, 1'b0, UNTYPED},
        '{24'd7, 24'd7, 24'd7, 1'b0, 1'b0, UNTYPED},
        '{24'd7, 24'd7, 24'd7, 1'b0, 1'b0,
          '{1'b1, 12'd8, 12'd8, 12'd8,
            ftvd_pkg::STATUS_NEW, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED}},
        '{24'hAAAAAA, 24'h555555, 24'hAAAAAA, 1'b0, 1'b0,
          '{1'b1, 12'd8, 12'd8, 12'd9,
            ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_NEW}},
        '{24'h555555, 24'hAAAAAA, 24'h555555, 1'b0, 1'b0,
          '{1'b1, 12'd8, 12'd9, 12'd10,
            ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_NEW}},
        // An all-reused triangle that carries a piece start.
        '{24'd0, 24'd0, 24'd0, 1'b1, 1'b1, UNTYPED},
        '{24'd0, 24'd0, 24'd0, 1'b0, 1'b0, UNTYPED},
        '{24'd0, 24'd0, 24'd0, 1'b0, 1'b0,
          '{1'b1, 12'd0, 12'd0, 12'd0,
            ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED, ftvd_pkg::STATUS_REUSED}}
    };

    logic                         clk;
    logic                         rst_n;
    logic                         corner_valid;
    logic                         corner_stall;
    corner_in_t                   offered;
    logic                         result_valid;
    logic                         result_stall;
    logic [ftvd_pkg::VIDX_W-1:0]  vertex_index;
    logic [1:0]                   status;
    logic [ftvd_pkg::FIELD_W-1:0] out_pos;
    logic [ftvd_pkg::FIELD_W-1:0] out_coord;
    logic [ftvd_pkg::FIELD_W-1:0] out_normal;
    logic                         piece_begin;
    logic                         last;

    // Predictor state: face tracking and the table of unique triples.
    ftvd_pkg::key_t               anchor_key;
    ftvd_pkg::key_t               prev_key;
    int                           corners_seen;
    logic                         piece_waiting;
    int                           vertex_count;
    ftvd_pkg::key_t               vertex_table [ftvd_pkg::TABLE_CAPACITY];
    corner_result_t               expected_corners [$];

    int                           error_count;
    int                           cycle_count;
    logic                         holdoff_request;

    fan_triangulate_vertex_dedup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .corner_valid  (corner_valid),
        .corner_stall  (corner_stall),
        .pos_index     (offered.pos),
        .coord_index   (offered.coord),
        .normal_index  (offered.normal),
        .first_of_face (offered.first),
        .piece_start   (offered.piece),
        .result_valid  (result_valid),
        .result_stall  (result_stall),
        .vertex_index  (vertex_index),
        .status        (status),
        .out_pos       (out_pos),
        .out_coord     (out_coord),
        .out_normal    (out_normal),
        .piece_begin   (piece_begin),
        .last          (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Run-length guard.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("fan_triangulate_vertex_dedup regression: fail");
        $finish;
    end

    // Look one triangle corner up in the predicted table and queue its result.
    task automatic look_up(input ftvd_pkg::key_t key, input logic is_last,
                           input logic typed,
                           input logic [ftvd_pkg::VIDX_W-1:0] typed_vidx,
                           input ftvd_pkg::status_t typed_st);
        corner_result_t r;
        int k;
        r.vidx = '0;
        r.st = ftvd_pkg::STATUS_FULL;
        k = 0;
        while (k < vertex_count && r.st == ftvd_pkg::STATUS_FULL)
        begin
            if (vertex_table[k] == key)
            begin
                r.vidx = k[ftvd_pkg::VIDX_W-1:0];
                r.st = ftvd_pkg::STATUS_REUSED;
            end
            k++;
        end
        if (r.st == ftvd_pkg::STATUS_FULL && vertex_count < ftvd_pkg::TABLE_CAPACITY)
        begin
            vertex_table[vertex_count] = key;
            r.vidx = vertex_count[ftvd_pkg::VIDX_W-1:0];
            r.st = ftvd_pkg::STATUS_NEW;
            vertex_count++;
        end
        if (typed)
        begin
            r.vidx = typed_vidx;
            r.st = typed_st;
        end
        r.pos = key.pos;
        r.coord = key.coord;
        r.normal = key.normal;
        r.piece = piece_waiting;
        r.is_last = is_last;
        piece_waiting = 1'b0;
        expected_corners = {expected_corners, r};
    endtask

    // Advance the face state by one accepted corner.
    task automatic predict_corner(input corner_in_t item);
        ftvd_pkg::key_t cur;
        cur.pos = item.pos[ftvd_pkg::ID_BITS-1:0];
        cur.coord = item.coord[ftvd_pkg::ID_BITS-1:0];
        cur.normal = item.normal[ftvd_pkg::ID_BITS-1:0];
        if (item.piece)
            piece_waiting = 1'b1;
        if (item.first || corners_seen == 0)
        begin
            anchor_key = cur;
            corners_seen = 1;
        end
        else if (corners_seen == 1)
        begin
            corners_seen = 2;
        end
        else
        begin
            look_up(anchor_key, 1'b0, item.want.typed, item.want.vidx0, item.want.st0);
            look_up(prev_key, 1'b0, item.want.typed, item.want.vidx1, item.want.st1);
            look_up(cur, 1'b1, item.want.typed, item.want.vidx2, item.want.st2);
        end
        prev_key = cur;
    endtask

    // Compare one accepted result with the oldest expectation.
    task automatic check_result();
        corner_result_t got;
        corner_result_t want;
        got = '{vertex_index, status, out_pos, out_coord, out_normal, piece_begin, last};
        if (expected_corners.size() == 0)
        begin
            $display("%0t: result with nothing expected: idx %0d st %0d pos %h coord %h norm %h",
                     $time, got.vidx, got.st, got.pos, got.coord, got.normal);
            error_count++;
        end
        else
        begin
            want = expected_corners.pop_front();
            if (got !== want)
            begin
                $display("%0t: mismatch expected idx %0d st %0d pos %h coord %h norm %h pb %b last %b",
                         $time, want.vidx, want.st, want.pos, want.coord, want.normal,
                         want.piece, want.is_last);
                $display("%0t:          actual   idx %0d st %0d pos %h coord %h norm %h pb %b last %b",
                         $time, got.vidx, got.st, got.pos, got.coord, got.normal,
                         got.piece, got.is_last);
                error_count++;
            end
        end
    endtask

    // Sample both channels at the rising edge; results first, so a corner taken
    // in the same cycle never lines up with an older result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                check_result();
            if (corner_valid && !corner_stall)
                predict_corner(offered);
        end
    end

    // Receiver: random stall patterns, plus one long hold-off once asked for.
    initial
    begin : receiver
        int mode;
        int span;
        bit holdoff_done;
        result_stall = 1'b0;
        holdoff_done = 1'b0;
        forever
        begin
            if (holdoff_request && !holdoff_done)
            begin
                repeat (HOLDOFF_CYCLES)
                begin
                    @(negedge clk);
                    result_stall <= 1'b1;
                end
                holdoff_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 150);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 1) == 1);
                    2: result_stall <= ($urandom_range(0, 9) < 8);
                    default: result_stall <= ((cycle_count % 5) < 2);
                endcase
            end
        end
    end

    // Offer one corner after a gap, and hold it until it is taken.
    task automatic send_corner(input corner_in_t item, input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            corner_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        corner_valid <= 1'b1;
        offered <= item;
        do
            @(posedge clk);
        while (corner_stall);
    endtask

    // Drop valid and wait until every expected result has arrived.
    task automatic drain();
        @(negedge clk);
        corner_valid <= 1'b0;
        while (expected_corners.size() != 0)
            @(negedge clk);
    endtask

    // Mostly a small pool so lookups hit, sometimes extremes or wide values.
    function automatic logic [ftvd_pkg::FIELD_W-1:0] pick_index();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 72)
            return ftvd_pkg::FIELD_W'($urandom_range(0, 5));
        else if (roll < 80)
            return ABSENT;
        else if (roll < 86)
            return '0;
        else
            return ftvd_pkg::FIELD_W'($urandom);
    endfunction

    initial
    begin : stimulus
        corner_in_t item;
        int random_sent;
        int face_len;
        int shape;
        int burst_left;
        int gap;
        bit paused;

        rst_n = 1'b0;
        corner_valid = 1'b0;
        offered = '0;
        error_count = 0;
        holdoff_request = 1'b0;
        anchor_key = '0;
        prev_key = '0;
        corners_seen = 0;
        piece_waiting = 1'b0;
        vertex_count = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows.
        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_corner(DIRECTED_ROWS[i],
                        ($urandom_range(0, 1) == 1) ? $urandom_range(1, 3) : 0);
        drain();

        // Random faces: mostly well formed, some short faces and stray continuations.
        holdoff_request = 1'b1;
        random_sent = 0;
        burst_left = 0;
        paused = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            shape = $urandom_range(0, 9);
            if (shape < 8)
                face_len = $urandom_range(3, 6);
            else
                face_len = $urandom_range(1, 3);
            for (int k = 0; k < face_len; k++)
            begin
                item.pos = pick_index();
                item.coord = pick_index();
                item.normal = pick_index();
                item.first = (shape != 9) && (k == 0);
                item.piece = ((k == 0) && ($urandom_range(0, 9) == 0)) ||
                             ($urandom_range(0, 24) == 0);
                item.want = UNTYPED;
                if (burst_left == 0)
                begin
                    gap = $urandom_range(1, 15);
                    burst_left = $urandom_range(1, 24);
                end
                else
                begin
                    gap = 0;
                    burst_left--;
                end
                send_corner(item, gap);
                random_sent++;
            end
            if (!paused && random_sent >= RANDOM_ITEMS / 2)
            begin
                drain();
                paused = 1'b1;
            end
        end

        // Let the block settle, then report.
        drain();
        repeat (3 * (vertex_count + 5) + 50) @(posedge clk);
        if (error_count == 0)
            $display("fan_triangulate_vertex_dedup regression: pass");
        else
            $display("fan_triangulate_vertex_dedup regression: fail");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/ftvd_pkg.sv
hw/rtl/ftvd_ram.sv
hw/rtl/ftvd_search.sv
hw/rtl/fan_triangulate_vertex_dedup.sv
dv/testbench.sv
